// File: rtl/core/smsup_pkg.sv
// shared types and constants of the sms user-data septet packer
// used by smsup_front, smsup_job_fifo, smsup_back and the top level
package smsup_pkg;

    // format mode codes
    localparam logic [1:0] MODE_TEXT7     = 2'd0;
    localparam logic [1:0] MODE_TWO_OCTET = 2'd1;
    localparam logic [1:0] MODE_HEX       = 2'd2;

    // character limits per mode
    localparam logic [7:0] LIMIT_TEXT7     = 8'd160;
    localparam logic [7:0] LIMIT_TWO_OCTET = 8'd70;
    localparam logic [7:0] LIMIT_HEX       = 8'd80;

    // two-octet mode constants and the septet mask
    localparam logic [7:0] HIGH_CHAR_BASE = 8'hC0;
    localparam logic [7:0] HIGH_CHAR_OFFS = 8'hB0;
    localparam logic [7:0] HIGH_CHAR_PAGE = 8'h04;
    localparam logic [7:0] LOW_CHAR_PAGE  = 8'h00;
    localparam logic [6:0] SEPTET_MASK    = 7'h7F;

    // results of one item, slots 0 .. cnt-1 valid
    localparam int JOB_SLOTS = 3;

    typedef struct packed {
        logic [JOB_SLOTS-1:0][7:0] oct;
        logic [1:0]                cnt;
        logic                      eom;
        logic                      nodata;
    } t_job;

    // job queue status seen by the top level and back
    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_status;

endpackage

// File: rtl/core/smsup_front.sv
// front part: accepts characters, holds mode and packing state, builds one job per item
// depends on smsup_pkg
module smsup_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_wdata,
    input  logic               i_accept,
    input  logic [7:0]         i_char_code,
    input  logic               i_final_char,
    output logic               o_job_push,
    output smsup_pkg::t_job    o_job
);
    import smsup_pkg::*;

    typedef struct packed {
        logic       emit;
        logic [7:0] octet;
        logic [7:0] acc;
        logic [2:0] fill;
    } t_pack;

    // merge one septet into the partial octet
    function automatic t_pack pack_septet(input logic [7:0] acc, input logic [2:0] fill,
                                          input logic [6:0] sept);
        t_pack      res;
        logic [7:0] merged;
        merged = acc | 8'(({1'b0, sept}) << fill);
        if (fill != 3'd0) begin
            res.emit  = 1'b1;
            res.octet = merged;
            res.acc   = 8'({1'b0, sept} >> (4'd8 - {1'b0, fill}));
            res.fill  = fill - 3'd1;
        end else begin
            res.emit  = 1'b0;
            res.octet = merged;
            res.acc   = merged;
            res.fill  = 3'd7;
        end
        return res;
    endfunction

    // uppercase ascii hex digit
    function automatic logic [6:0] hex_digit(input logic [3:0] nib);
        logic [6:0] d;
        if (nib >= 4'd10) begin
            d = 7'({3'd0, nib} + 7'd55);
        end else begin
            d = 7'({3'd0, nib} + 7'd48);
        end
        return d;
    endfunction

    logic [1:0] r_mode;
    logic [7:0] r_acc, n_acc;
    logic [2:0] r_fill, n_fill;
    logic [7:0] r_count, n_count;

    logic [7:0] limit;
    logic       take;
    logic [6:0] sept_a;
    t_pack      p1, p2;
    t_job       job;
    logic [1:0] k;

    // mode limit, first septet and the packing of both septets
    always_comb begin
        case (r_mode)
            MODE_TEXT7:     limit = LIMIT_TEXT7;
            MODE_TWO_OCTET: limit = LIMIT_TWO_OCTET;
            MODE_HEX:       limit = LIMIT_HEX;
            default:        limit = 8'd0;
        endcase
        take   = r_count < limit;
        sept_a = (r_mode == MODE_HEX) ? hex_digit(i_char_code[7:4])
                                      : (i_char_code[6:0] & SEPTET_MASK);
        p1     = pack_septet(r_acc, r_fill, sept_a);
        p2     = pack_septet(p1.acc, p1.fill, hex_digit(i_char_code[3:0]));
    end

    // build the job and next packing state
    always_comb begin
        job     = '0;
        k       = 2'd0;
        n_acc   = r_acc;
        n_fill  = r_fill;
        n_count = r_count;
        if (take) begin
            n_count = r_count + 8'd1;
            case (r_mode)
                MODE_TEXT7: begin
                    if (p1.emit) begin
                        job.oct[k] = p1.octet;
                        k          = k + 2'd1;
                    end
                    n_acc  = p1.acc;
                    n_fill = p1.fill;
                end
                MODE_TWO_OCTET: begin
                    if (i_char_code >= HIGH_CHAR_BASE) begin
                        job.oct[0] = HIGH_CHAR_PAGE;
                        job.oct[1] = i_char_code - HIGH_CHAR_OFFS;
                    end else begin
                        job.oct[0] = LOW_CHAR_PAGE;
                        job.oct[1] = i_char_code;
                    end
                    k = 2'd2;
                end
                MODE_HEX: begin
                    if (p1.emit) begin
                        job.oct[k] = p1.octet;
                        k          = k + 2'd1;
                    end
                    if (p2.emit) begin
                        job.oct[k] = p2.octet;
                        k          = k + 2'd1;
                    end
                    n_acc  = p2.acc;
                    n_fill = p2.fill;
                end
                default: begin
                    k = 2'd0;
                end
            endcase
        end
        // end of message: flush and mark
        if (i_final_char) begin
            if (n_fill != 3'd0) begin
                job.oct[k] = n_acc;
                k          = k + 2'd1;
            end
            if (k == 2'd0) begin
                job.oct[0] = 8'd0;
                job.nodata = 1'b1;
                k          = 2'd1;
            end
            job.eom = 1'b1;
            n_acc   = 8'd0;
            n_fill  = 3'd0;
            n_count = 8'd0;
        end
        job.cnt = k;
    end

    assign o_job      = job;
    assign o_job_push = i_accept && (k != 2'd0);

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TEXT7;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // packing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= 8'd0;
            r_fill  <= 3'd0;
            r_count <= 8'd0;
        end else if (i_accept) begin
            r_acc   <= n_acc;
            r_fill  <= n_fill;
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/core/smsup_job_fifo.sv
// two-entry job queue between front and back parts
// depends on smsup_pkg
module smsup_job_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  smsup_pkg::t_job      i_job,
    input  logic                 i_pop,
    output smsup_pkg::t_job      o_job,
    output smsup_pkg::t_q_status o_status
);
    import smsup_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count, n_count;
    logic       do_push, do_pop;

    assign o_status.full     = (r_count == 2'd2);
    assign o_status.nonempty = (r_count != 2'd0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && o_status.nonempty;
    assign o_job   = r_mem[r_rptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

// File: rtl/core/smsup_back.sv
// back part: takes jobs from the queue and hands out one result item per cycle while popped
// depends on smsup_pkg
module smsup_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  smsup_pkg::t_job      i_job,
    input  smsup_pkg::t_q_status i_q_status,
    output logic                 o_q_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [7:0]           o_octet,
    output logic                 o_no_data,
    output logic                 o_end_of_message
);
    import smsup_pkg::*;

    t_job       r_job;
    logic       r_valid;
    logic [1:0] r_idx;
    logic       last;
    logic       load;

    assign last    = (r_idx == (r_job.cnt - 2'd1));
    assign load    = !r_valid || (i_pop && last);
    assign o_q_pop = load && i_q_status.nonempty;

    // result ports
    assign o_empty          = !r_valid;
    assign o_octet          = r_job.oct[r_idx];
    assign o_no_data        = r_job.nodata;
    assign o_end_of_message = r_job.eom && last;

    // current job control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= i_q_status.nonempty;
            r_idx   <= 2'd0;
        end else if (i_pop) begin
            r_idx   <= r_idx + 2'd1;
        end
    end

    // current job payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx < r_job.cnt))
        else $error("result slot index beyond job size");
    a_job_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_job.cnt != 2'd0))
        else $error("empty job loaded");
    a_nodata_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_job.nodata) |-> (r_job.cnt == 2'd1 && r_job.eom))
        else $error("no-data marker not a lone end item");
    a_hold_unpopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_pop) |=> (r_valid && $stable(r_idx)))
        else $error("waiting result item changed without pop");
`endif

endmodule

// File: rtl/core/sms_user_data_septet_packer_top.sv
// path: an item is registered in the job queue, then in the back job register
// throughput: one character per cycle while the two-entry job queue has room; results
// leave at one item per cycle from the back part while popped; an item gives 0 to 3
// results (one or two in hex mode, two in two-octet mode, plus a flush)
// reset: synchronous, active low; clears mode to 7-bit text, packing state, queue, output
// depends on smsup_pkg, smsup_front, smsup_job_fifo, smsup_back
module sms_user_data_septet_packer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_char_code,
    input  logic       i_final_char,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_octet,
    output logic       o_no_data,
    output logic       o_end_of_message
);
    import smsup_pkg::*;

    t_job      front_job;
    logic      front_push;
    t_job      q_job;
    t_q_status q_status;
    logic      q_pop;
    logic      accept;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    // character intake and packing
    smsup_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (accept),
        .i_char_code  (i_char_code),
        .i_final_char (i_final_char),
        .o_job_push   (front_push),
        .o_job        (front_job)
    );

    // job queue
    smsup_job_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (front_push),
        .i_job    (front_job),
        .i_pop    (q_pop),
        .o_job    (q_job),
        .o_status (q_status)
    );

    // result output
    smsup_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job            (q_job),
        .i_q_status       (q_status),
        .o_q_pop          (q_pop),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_octet          (o_octet),
        .o_no_data        (o_no_data),
        .o_end_of_message (o_end_of_message)
    );

endmodule
